// File: src/bfc_pkg.sv
package bfc_pkg;

  // default bitmap size in bytes
  localparam int NumBytesDefault = 64;

  // memory word geometry: four bytes per word
  localparam int WordBytes = 4;
  localparam int WordBits  = 8 * WordBytes;

  // request opcodes
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_FIND  = 2'd1,
    OP_COUNT = 2'd2
  } op_e;

  // response status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NONE  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  // control states
  typedef enum logic [1:0] {
    FSM_CLEAR = 2'd0,
    FSM_IDLE  = 2'd1,
    FSM_SCAN  = 2'd2,
    FSM_DONE  = 2'd3
  } fsm_e;

  // input request
  typedef struct packed {
    logic [1:0] opcode;
    logic [5:0] byte_index;
    logic [7:0] byte_value;
    logic [8:0] start_bit;
    logic       polarity;
  } req_t;

  // output response
  typedef struct packed {
    logic [1:0] status;
    logic [8:0] position;
    logic [9:0] set_count;
  } rsp_t;

  // per-word scan result
  typedef struct packed {
    logic       hit;
    logic [4:0] idx;
    logic [5:0] ones;
  } eval_t;

  // ones in one byte
  function automatic logic [3:0] popcnt8(input logic [7:0] v);
    logic [3:0] c;
    c = 4'd0;
    for (int i = 0; i < 8; i++) begin
      c = c + 4'(v[i]);
    end
    return c;
  endfunction

endpackage

// File: src/bfc_word_eval.sv
module bfc_word_eval (
  input  logic [31:0]     word_i,
  input  logic [31:0]     mask_i,
  input  logic            polarity_i,
  output bfc_pkg::eval_t  res_o
);

  logic [31:0] target;
  logic [31:0] lowest;
  logic [31:0] kept;
  logic [4:0]  idx;

  // bits equal to the sought polarity, inside the valid window
  assign target = (word_i ^ {32{~polarity_i}}) & mask_i;
  assign lowest = target & (~target + 32'd1);
  assign kept   = word_i & mask_i;

  // one-hot to index
  always_comb begin
    idx = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (lowest[i]) begin
        idx = idx | 5'(i);
      end
    end
  end

  // per-byte population counts summed
  always_comb begin
    res_o.hit  = |target;
    res_o.idx  = idx;
    res_o.ones = 6'(bfc_pkg::popcnt8(kept[7:0]))   + 6'(bfc_pkg::popcnt8(kept[15:8]))
               + 6'(bfc_pkg::popcnt8(kept[23:16])) + 6'(bfc_pkg::popcnt8(kept[31:24]));
  end

endmodule

// File: src/bitmap_find_and_count_core.sv
// channel | dir | handshake                 | payload
// in      | in  | in_valid_i / in_stall_o   | in_req_i  (bfc_pkg::req_t)
// out     | out | out_valid_o / out_stall_i | out_rsp_o (bfc_pkg::rsp_t)
// cfg     | in  | cfg_valid_i / cfg_ready_o | cfg_data_i (bytes_in_use, 7 bits)
//
// A write goes to memory as it is accepted. A find or count reads the bitmap one
// 32-bit memory word per cycle through a single read port; a find stops at the first
// matching word, and a find whose start bit is out of range skips the scan. After
// reset a clearing pass zeroes the memory, one word a cycle; no request is taken
// meanwhile, config writes always are.
// A finished response waits in the output register while out_stall_i is high.
module bitmap_find_and_count_core #(
  parameter int NUM_BYTES = bfc_pkg::NumBytesDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  bfc_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output bfc_pkg::rsp_t out_rsp_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [6:0]    cfg_data_i
);

  localparam int Rows = (NUM_BYTES + bfc_pkg::WordBytes - 1) / bfc_pkg::WordBytes;
  localparam int RowW = (Rows > 1) ? $clog2(Rows) : 1;

  // bitmap memory
  logic [bfc_pkg::WordBits-1:0] store_mem [Rows];

  logic                         mem_we;
  logic [RowW-1:0]              mem_waddr;
  logic [3:0]                   mem_be;
  logic [bfc_pkg::WordBits-1:0] mem_wdata;
  logic                         mem_re;
  logic [bfc_pkg::WordBits-1:0] rd_data_q;

  // control registers
  bfc_pkg::fsm_e state_q, state_d;
  logic [RowW-1:0] clr_addr_q, clr_addr_d;
  logic [RowW-1:0] addr_q, addr_d;
  logic            issue_q, issue_d;
  logic            rd_vld_q, rd_vld_d;
  logic            out_valid_q, out_valid_d;
  logic [6:0]      bytes_in_use_q;

  // per-request payload registers
  logic [RowW-1:0] rd_row_q, rd_row_d;
  logic            find_q, find_d;
  logic            pol_q, pol_d;
  logic [4:0]      start_lo_q, start_lo_d;
  logic [RowW-1:0] first_row_q, first_row_d;
  logic [RowW-1:0] last_row_q, last_row_d;
  logic [3:0]      last_be_q, last_be_d;
  logic [1:0]      res_status_q, res_status_d;
  logic [8:0]      res_pos_q, res_pos_d;
  logic [9:0]      cnt_q, cnt_d;
  bfc_pkg::rsp_t   out_rsp_q, out_rsp_d;

  // derived request values
  logic [6:0]  nbytes;
  logic [9:0]  limit;
  logic [12:0] wr_row_full;
  logic [12:0] first_row_full;
  logic [12:0] last_row_full;
  logic [3:0]  tail_be;
  logic        accept;
  logic        out_free;

  // scan datapath
  logic [31:0]     scan_mask;
  logic [15:0]     pos_full;
  bfc_pkg::eval_t  ev;

  // active bytes, clipped to the store size
  assign nbytes = (13'(bytes_in_use_q) > 13'(NUM_BYTES)) ? 7'(NUM_BYTES) : bytes_in_use_q;
  assign limit  = {nbytes, 3'b000};

  assign wr_row_full    = 13'(in_req_i.byte_index) >> 2;
  assign first_row_full = 13'(in_req_i.start_bit) >> 5;
  assign last_row_full  = (13'(nbytes) - 13'd1) >> 2;

  // byte enables of the last word in use
  always_comb begin
    case (nbytes[1:0])
      2'd1:    tail_be = 4'b0001;
      2'd2:    tail_be = 4'b0011;
      2'd3:    tail_be = 4'b0111;
      default: tail_be = 4'b1111;
    endcase
  end

  assign accept   = in_valid_i && (state_q == bfc_pkg::FSM_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  // window of bits that count in the word under evaluation
  always_comb begin
    scan_mask = '1;
    if (find_q && (rd_row_q == first_row_q)) begin
      scan_mask = scan_mask & ('1 << start_lo_q);
    end
    if (rd_row_q == last_row_q) begin
      for (int l = 0; l < 4; l++) begin
        scan_mask[l*8 +: 8] = scan_mask[l*8 +: 8] & {8{last_be_q[l]}};
      end
    end
  end

  bfc_word_eval u_eval (
    .word_i     (rd_data_q),
    .mask_i     (scan_mask),
    .polarity_i (pol_q),
    .res_o      (ev)
  );

  assign pos_full = 16'({rd_row_q, ev.idx});

  // sequencer
  always_comb begin
    state_d      = state_q;
    clr_addr_d   = clr_addr_q;
    addr_d       = addr_q;
    issue_d      = issue_q;
    rd_vld_d     = 1'b0;
    rd_row_d     = rd_row_q;
    find_d       = find_q;
    pol_d        = pol_q;
    start_lo_d   = start_lo_q;
    first_row_d  = first_row_q;
    last_row_d   = last_row_q;
    last_be_d    = last_be_q;
    res_status_d = res_status_q;
    res_pos_d    = res_pos_q;
    cnt_d        = cnt_q;
    out_rsp_d    = out_rsp_q;
    out_valid_d  = out_valid_q && out_stall_i;
    mem_we       = 1'b0;
    mem_waddr    = clr_addr_q;
    mem_be       = 4'b1111;
    mem_wdata    = '0;
    mem_re       = 1'b0;

    case (state_q)
      bfc_pkg::FSM_CLEAR: begin
        mem_we     = 1'b1;
        clr_addr_d = clr_addr_q + RowW'(1);
        if (clr_addr_q == RowW'(Rows - 1)) begin
          state_d = bfc_pkg::FSM_IDLE;
        end
      end

      bfc_pkg::FSM_IDLE: begin
        if (accept) begin
          find_d      = 1'b0;
          pol_d       = in_req_i.polarity;
          start_lo_d  = in_req_i.start_bit[4:0];
          first_row_d = first_row_full[RowW-1:0];
          last_row_d  = last_row_full[RowW-1:0];
          last_be_d   = tail_be;
          res_pos_d   = '0;
          cnt_d       = '0;
          case (in_req_i.opcode)
            bfc_pkg::OP_WRITE: begin
              if (13'(in_req_i.byte_index) < 13'(NUM_BYTES)) begin
                mem_we    = 1'b1;
                mem_waddr = wr_row_full[RowW-1:0];
                mem_be    = 4'b0001 << in_req_i.byte_index[1:0];
                mem_wdata = {4{in_req_i.byte_value}};
              end
            end
            bfc_pkg::OP_FIND: begin
              find_d = 1'b1;
              if (10'(in_req_i.start_bit) >= limit) begin
                res_status_d = bfc_pkg::ST_RANGE;
                state_d      = bfc_pkg::FSM_DONE;
              end else begin
                res_status_d = bfc_pkg::ST_NONE;
                addr_d       = first_row_full[RowW-1:0];
                issue_d      = 1'b1;
                state_d      = bfc_pkg::FSM_SCAN;
              end
            end
            bfc_pkg::OP_COUNT: begin
              res_status_d = bfc_pkg::ST_OK;
              if (nbytes == 7'd0) begin
                state_d = bfc_pkg::FSM_DONE;
              end else begin
                addr_d  = '0;
                issue_d = 1'b1;
                state_d = bfc_pkg::FSM_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end

      bfc_pkg::FSM_SCAN: begin
        // issue the next word read
        if (issue_q) begin
          mem_re   = 1'b1;
          rd_vld_d = 1'b1;
          rd_row_d = addr_q;
          addr_d   = addr_q + RowW'(1);
          issue_d  = (addr_q != last_row_q);
        end
        // evaluate the word read last cycle
        if (rd_vld_q) begin
          if (find_q) begin
            if (ev.hit) begin
              res_status_d = bfc_pkg::ST_OK;
              res_pos_d    = pos_full[8:0];
              state_d      = bfc_pkg::FSM_DONE;
            end else if (rd_row_q == last_row_q) begin
              state_d = bfc_pkg::FSM_DONE;
            end
          end else begin
            cnt_d = cnt_q + 10'(ev.ones);
            if (rd_row_q == last_row_q) begin
              state_d = bfc_pkg::FSM_DONE;
            end
          end
          if (state_d == bfc_pkg::FSM_DONE) begin
            issue_d  = 1'b0;
            rd_vld_d = 1'b0;
          end
        end
      end

      bfc_pkg::FSM_DONE: begin
        if (out_free) begin
          out_valid_d         = 1'b1;
          out_rsp_d.status    = res_status_q;
          out_rsp_d.position  = res_pos_q;
          out_rsp_d.set_count = cnt_q;
          state_d             = bfc_pkg::FSM_IDLE;
        end
      end

      default: begin
        state_d = bfc_pkg::FSM_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bfc_pkg::FSM_CLEAR;
      clr_addr_q  <= '0;
      addr_q      <= '0;
      issue_q     <= 1'b0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_addr_q  <= clr_addr_d;
      addr_q      <= addr_d;
      issue_q     <= issue_d;
      rd_vld_q    <= rd_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_in_use_q <= 7'd64;
    end else if (cfg_valid_i && cfg_ready_o) begin
      bytes_in_use_q <= cfg_data_i;
    end
  end

  // request payload
  always_ff @(posedge clk_i) begin
    rd_row_q     <= rd_row_d;
    find_q       <= find_d;
    pol_q        <= pol_d;
    start_lo_q   <= start_lo_d;
    first_row_q  <= first_row_d;
    last_row_q   <= last_row_d;
    last_be_q    <= last_be_d;
    res_status_q <= res_status_d;
    res_pos_q    <= res_pos_d;
    cnt_q        <= cnt_d;
    out_rsp_q    <= out_rsp_d;
  end

  // memory write with byte enables
  always_ff @(posedge clk_i) begin
    for (int l = 0; l < bfc_pkg::WordBytes; l++) begin
      if (mem_we && mem_be[l]) begin
        store_mem[mem_waddr][l*8 +: 8] <= mem_wdata[l*8 +: 8];
      end
    end
  end

  // memory read, registered data
  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rd_data_q <= store_mem[addr_q];
    end
  end

  assign in_stall_o  = (state_q != bfc_pkg::FSM_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;
  assign cfg_ready_o = 1'b1;

endmodule

// File: test/tb.sv
module tb;
  import bfc_pkg::*;

  localparam int NumBytes    = NumBytesDefault;
  localparam int GapMax      = 13;
  localparam int LongHold    = 250;
  localparam int SettleWait  = 24;
  localparam int StuckLimit  = 2000;
  localparam int PhaseItems  = 110;
  localparam logic [1:0] OpUnused = 2'd3;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  req_t       in_req_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  rsp_t       out_rsp_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [6:0] cfg_data_i = '0;

  bitmap_find_and_count_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // shadow copy of the bitmap and the bytes-in-use register
  logic [7:0] shadow_map [NumBytes];
  logic [6:0] shadow_in_use;

  rsp_t pending_rsp_q [$];
  int   mismatches;
  int   rsp_checked;
  int   n_write, n_find, n_count, n_unused, n_cfg;
  int   stuck_cycles;
  bit   sender_gaps;
  bit   rx_gaps;
  bit   long_hold_req;

  // directed stimulus row
  typedef struct {
    bit         is_cfg;
    logic [6:0] cfg;
    req_t       req;
    bit         typed;
    rsp_t       want;
  } dir_row_t;

  dir_row_t dir_tbl [$];

  function automatic dir_row_t row(bit is_cfg, logic [6:0] cfg, logic [1:0] op,
                                   logic [5:0] idx, logic [7:0] val, logic [8:0] start,
                                   logic pol, bit typed, status_e st, logic [8:0] pos,
                                   logic [9:0] cnt);
    dir_row_t r;
    r.is_cfg             = is_cfg;
    r.cfg                = cfg;
    r.req.opcode         = op;
    r.req.byte_index     = idx;
    r.req.byte_value     = val;
    r.req.start_bit      = start;
    r.req.polarity       = pol;
    r.typed              = typed;
    r.want.status        = st;
    r.want.position      = pos;
    r.want.set_count     = cnt;
    return r;
  endfunction

  // bytes actually searched and counted
  function automatic int unsigned bytes_active();
    return (shadow_in_use > NumBytes) ? NumBytes : int'(shadow_in_use);
  endfunction

  // apply one request to the shadow bitmap, return 1 when it yields a response
  function automatic bit bitmap_apply(input req_t r, output rsp_t rsp);
    int unsigned lim;
    bit          hit;
    bit          has_rsp;
    rsp     = '0;
    has_rsp = 1'b0;
    lim     = bytes_active() * 8;
    case (r.opcode)
      OP_WRITE: begin
        if (r.byte_index < NumBytes) shadow_map[r.byte_index] = r.byte_value;
      end
      OP_FIND: begin
        has_rsp = 1'b1;
        if (r.start_bit >= lim) begin
          rsp.status = ST_RANGE;
        end else begin
          hit = 1'b0;
          for (int b = r.start_bit; b < lim && !hit; b++) begin
            if (shadow_map[b >> 3][b & 7] == r.polarity) begin
              hit          = 1'b1;
              rsp.position = 9'(b);
            end
          end
          rsp.status = hit ? ST_OK : ST_NONE;
        end
      end
      OP_COUNT: begin
        has_rsp = 1'b1;
        rsp.status = ST_OK;
        for (int i = 0; i < lim / 8; i++) begin
          rsp.set_count = rsp.set_count + 10'($countones(shadow_map[i]));
        end
      end
      default: ;
    endcase
    return has_rsp;
  endfunction

  // offer one request and wait until it is taken
  task automatic send_req(input req_t r, input bit typed, input rsp_t want);
    rsp_t pred;
    if (sender_gaps && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, GapMax)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    case (r.opcode)
      OP_WRITE: n_write++;
      OP_FIND:  n_find++;
      OP_COUNT: n_count++;
      default:  n_unused++;
    endcase
    if (bitmap_apply(r, pred)) pending_rsp_q.push_back(typed ? want : pred);
  endtask

  // let the block run dry, then write bytes_in_use
  task automatic write_bytes_in_use(input logic [6:0] v);
    in_valid_i <= 1'b0;
    while (pending_rsp_q.size() != 0) @(posedge clk_i);
    repeat (SettleWait) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    shadow_in_use = v;
    n_cfg++;
    cfg_valid_i <= 1'b0;
  endtask

  // random request, weighted toward writes and finds within the bytes in use
  function automatic req_t rand_req();
    req_t        r;
    int unsigned nb;
    int unsigned pick;
    nb   = bytes_active();
    pick = $urandom_range(0, 99);
    if (pick < 45)      r.opcode = OP_WRITE;
    else if (pick < 80) r.opcode = OP_FIND;
    else if (pick < 96) r.opcode = OP_COUNT;
    else                r.opcode = OpUnused;
    if (nb == 0 || $urandom_range(0, 7) == 0) r.byte_index = 6'($urandom_range(0, 63));
    else r.byte_index = 6'($urandom_range(0, nb - 1));
    case ($urandom_range(0, 4))
      0:       r.byte_value = 8'h00;
      1:       r.byte_value = 8'hFF;
      2:       r.byte_value = 8'(1 << $urandom_range(0, 7));
      3:       r.byte_value = ~8'(1 << $urandom_range(0, 7));
      default: r.byte_value = 8'($urandom_range(0, 255));
    endcase
    if (nb == 0 || $urandom_range(0, 7) == 0) r.start_bit = 9'($urandom_range(0, 511));
    else r.start_bit = 9'($urandom_range(0, nb * 8 - 1));
    r.polarity = 1'($urandom_range(0, 1));
    return r;
  endfunction

  // receiver: random stall bursts, one long hold on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (LongHold) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (rx_gaps && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, GapMax)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // response checker and progress tracking
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
      end
      if (out_valid_o && !out_stall_i) begin
        if (pending_rsp_q.size() == 0) begin
          $display("%0t: unexpected response status %0d position %0d set_count %0d", $time,
                   out_rsp_o.status, out_rsp_o.position, out_rsp_o.set_count);
          mismatches++;
        end else begin
          want = pending_rsp_q.pop_front();
          rsp_checked++;
          if (out_rsp_o.status !== want.status) begin
            $display("%0t: status expected %0d got %0d", $time, want.status,
                     out_rsp_o.status);
            mismatches++;
          end
          if (out_rsp_o.position !== want.position) begin
            $display("%0t: position expected %0d got %0d", $time, want.position,
                     out_rsp_o.position);
            mismatches++;
          end
          if (out_rsp_o.set_count !== want.set_count) begin
            $display("%0t: set_count expected %0d got %0d", $time, want.set_count,
                     out_rsp_o.set_count);
            mismatches++;
          end
        end
      end
    end
  end

  // watchdog on a stuck handshake
  initial begin
    stuck_cycles = 0;
    while (stuck_cycles < StuckLimit) @(posedge clk_i);
    $display("%0t: no progress for %0d cycles", $time, StuckLimit);
    $display("[FAIL] regression broken");
    $finish;
  end

  // stimulus
  initial begin
    logic [6:0] phase_cfg [5];
    mismatches    = 0;
    rsp_checked   = 0;
    n_write       = 0;
    n_find        = 0;
    n_count       = 0;
    n_unused      = 0;
    n_cfg         = 0;
    sender_gaps   = 1'b1;
    rx_gaps       = 1'b1;
    long_hold_req = 1'b0;
    shadow_in_use = 7'd64;
    for (int i = 0; i < NumBytes; i++) shadow_map[i] = '0;

    // directed: empty map, extremes, the bytes-in-use corner values
    dir_tbl.push_back(row(0, 0, OP_COUNT, 0, 0, 0, 0, 1, ST_OK, 0, 0));
    dir_tbl.push_back(row(0, 0, OP_FIND, 0, 0, 0, 1, 1, ST_NONE, 0, 0));
    dir_tbl.push_back(row(0, 0, OP_FIND, 0, 0, 0, 0, 1, ST_OK, 0, 0));
    dir_tbl.push_back(row(0, 0, OP_FIND, 0, 0, 511, 0, 1, ST_OK, 511, 0));
    dir_tbl.push_back(row(0, 0, OP_FIND, 63, 255, 511, 1, 1, ST_NONE, 0, 0));
    dir_tbl.push_back(row(0, 0, OP_WRITE, 0, 8'hFF, 0, 0, 0, ST_OK, 0, 0));
    dir_tbl.push_back(row(0, 0, OP_WRITE, 63, 8'h80, 0, 0, 0, ST_OK, 0, 0));
    dir_tbl.push_back(row(0, 0, OP_COUNT, 0, 0, 0, 0, 1, ST_OK, 0, 9));
    dir_tbl.push_back(row(0, 0, OP_FIND, 0, 0, 0, 0, 0, ST_OK, 0, 0));
    dir_tbl.push_back(row(0, 0, OP_FIND, 0, 0, 1, 1, 0, ST_OK, 0, 0));
    dir_tbl.push_back(row(0, 0, OP_FIND, 0, 0, 8, 1, 0, ST_OK, 0, 0));
    dir_tbl.push_back(row(0, 0, OP_WRITE, 31, 8'h01, 0, 0, 0, ST_OK, 0, 0));
    dir_tbl.push_back(row(0, 0, OP_FIND, 0, 0, 9, 1, 0, ST_OK, 0, 0));
    dir_tbl.push_back(row(0, 0, OpUnused, 63, 8'hFF, 511, 1, 0, ST_OK, 0, 0));
    dir_tbl.push_back(row(0, 0, OP_WRITE, 42, 8'h5A, 0, 0, 0, ST_OK, 0, 0));
    dir_tbl.push_back(row(0, 0, OP_COUNT, 0, 0, 0, 0, 0, ST_OK, 0, 0));
    dir_tbl.push_back(row(0, 0, OP_FIND, 0, 0, 337, 1, 0, ST_OK, 0, 0));
    dir_tbl.push_back(row(1, 1, OP_WRITE, 0, 0, 0, 0, 0, ST_OK, 0, 0));
    dir_tbl.push_back(row(0, 0, OP_FIND, 0, 0, 8, 1, 1, ST_RANGE, 0, 0));
    dir_tbl.push_back(row(0, 0, OP_FIND, 0, 0, 7, 0, 0, ST_OK, 0, 0));
    dir_tbl.push_back(row(0, 0, OP_COUNT, 0, 0, 0, 0, 0, ST_OK, 0, 0));
    dir_tbl.push_back(row(1, 0, OP_WRITE, 0, 0, 0, 0, 0, ST_OK, 0, 0));
    dir_tbl.push_back(row(0, 0, OP_FIND, 0, 0, 0, 0, 1, ST_RANGE, 0, 0));
    dir_tbl.push_back(row(0, 0, OP_COUNT, 0, 0, 0, 0, 1, ST_OK, 0, 0));
    dir_tbl.push_back(row(1, 127, OP_WRITE, 0, 0, 0, 0, 0, ST_OK, 0, 0));
    dir_tbl.push_back(row(0, 0, OP_COUNT, 0, 0, 0, 0, 0, ST_OK, 0, 0));
    dir_tbl.push_back(row(0, 0, OP_FIND, 0, 0, 504, 1, 0, ST_OK, 0, 0));

    phase_cfg[0] = 7'd64;
    phase_cfg[1] = 7'd3;
    phase_cfg[2] = 7'd127;
    phase_cfg[3] = 7'($urandom_range(1, 64));
    phase_cfg[4] = 7'd64;

    // reset
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].is_cfg) write_bytes_in_use(dir_tbl[i].cfg);
      else send_req(dir_tbl[i].req, dir_tbl[i].typed, dir_tbl[i].want);
    end

    // random phases, one bytes-in-use setting each, last one without idling
    for (int p = 0; p < 5; p++) begin
      write_bytes_in_use(phase_cfg[p]);
      for (int n = 0; n < PhaseItems; n++) begin
        if (p == 4) begin
          sender_gaps = 1'b0;
          rx_gaps     = 1'b0;
        end else if (n % 40 == 0) begin
          sender_gaps = ($urandom_range(0, 2) != 0);
          rx_gaps     = ($urandom_range(0, 2) != 0);
        end
        // back up the output for a long stretch while requests keep coming
        if (p == 2 && n == 30) begin
          sender_gaps   = 1'b0;
          long_hold_req = 1'b1;
        end
        send_req(rand_req(), 1'b0, '0);
      end
    end
    in_valid_i <= 1'b0;

    // drain
    while (pending_rsp_q.size() != 0) @(posedge clk_i);
    repeat (SettleWait) @(posedge clk_i);

    $display("covered %0d writes, %0d finds, %0d counts, %0d unused opcodes, %0d responses",
             n_write, n_find, n_count, n_unused, rsp_checked);
    $display("across %0d bytes_in_use writes incl. 0, 1, 64 and 127, with one long hold",
             n_cfg);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
